// ----- hdl/hidkbd_pkg.sv -----
// Package with shared types and constants of the HID keyboard report engine.
package hidkbd_pkg;

  // Action codes carried in the input tuser.
  localparam logic [1:0] ActPress   = 2'd0;
  localparam logic [1:0] ActRelease = 2'd1;
  localparam logic [1:0] ActReady   = 2'd2;
  localparam logic [1:0] ActSetup   = 2'd3;

  // HID class request codes.
  localparam logic [7:0] RqGetReport   = 8'h01;
  localparam logic [7:0] RqGetIdle     = 8'h02;
  localparam logic [7:0] RqGetProtocol = 8'h03;
  localparam logic [7:0] RqSetReport   = 8'h09;
  localparam logic [7:0] RqSetIdle     = 8'h0A;
  localparam logic [7:0] RqSetProtocol = 8'h0B;

  // Request type decoding and report type for Get Report.
  localparam logic [7:0] TypeMask    = 8'h60;
  localparam logic [7:0] TypeClass   = 8'h20;
  localparam logic [7:0] ReportInput = 8'h01;

  // Reply kinds carried in the output tuser.
  localparam logic [1:0] KindNone     = 2'd0;
  localparam logic [1:0] KindReport   = 2'd1;
  localparam logic [1:0] KindProtocol = 2'd2;
  localparam logic [1:0] KindIdle     = 2'd3;

  // Number of slots that appear in the report.
  localparam int ShownSlots = 6;
  localparam int KeysW      = 8 * ShownSlots;

  typedef struct packed {
    logic [15:0] request_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
    logic        endpoint_busy;
    logic        link_active;
    logic [7:0]  key_code;
    logic [1:0]  action;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       reply_byte;
    logic [1:0]       reply_kind;
    logic             handled;
    logic [KeysW-1:0] report_keys;
    logic             send_report;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ----- hdl/hid_keyboard_report_engine_core.sv -----
// Top level of the HID keyboard report engine: stream ports, controller and datapath.
// An input transfer is captured into the input register, then executed into the result
// register once that register is free; a new item is taken only after the last is executed.
// The result register frees the input side, so a new item is taken while a result waits.
// Reset (rst_ni low, asynchronous) clears all key slots, the changed flag, the protocol
// and idle bytes, the controller state and the output valid.
module hid_keyboard_report_engine_core #(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: key_code[7:0], link_active, endpoint_busy, request_type[7:0],
  // request_code[7:0], request_value[15:0], zero fill to 48 bits.
  input  logic [47:0] s_axis_tdata,
  // tuser: action[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: send_report, report_keys[47:0], handled, reply_byte[7:0],
  // zero fill to 64 bits.
  output logic [63:0] m_axis_tdata,
  // tuser: reply_kind[1:0].
  output logic [1:0]  m_axis_tuser
);

  hidkbd_pkg::cmd_t      cmd;
  hidkbd_pkg::in_item_t  item;
  hidkbd_pkg::out_item_t result;

  // Unpack the input transfer into the item fields.
  always_comb begin
    item.action        = s_axis_tuser;
    item.key_code      = s_axis_tdata[7:0];
    item.link_active   = s_axis_tdata[8];
    item.endpoint_busy = s_axis_tdata[9];
    item.request_type  = s_axis_tdata[17:10];
    item.request_code  = s_axis_tdata[25:18];
    item.request_value = s_axis_tdata[41:26];
  end

  hidkbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  hidkbd_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item),
    .result_o (result)
  );

  // Pack the result register into the output transfer.
  assign m_axis_tdata = {6'd0, result.reply_byte, result.handled,
                         result.report_keys, result.send_report};
  assign m_axis_tuser = result.reply_kind;

endmodule

// ----- hdl/hidkbd_datapath.sv -----
// Datapath of the HID keyboard report engine: slots, flags, setup decoding, result register.
module hidkbd_datapath #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hidkbd_pkg::cmd_t     cmd_i,
  input  hidkbd_pkg::in_item_t item_i,
  output hidkbd_pkg::out_item_t result_o
);

  hidkbd_pkg::in_item_t  in_q;
  hidkbd_pkg::out_item_t out_q, out_d;

  logic [7:0] slot_q [KEY_SLOTS];
  logic [7:0] slot_d [KEY_SLOTS];
  logic       changed_q, changed_d;
  logic [7:0] protocol_q, protocol_d;
  logic [7:0] idle_q, idle_d;

  logic [KEY_SLOTS-1:0] hit_first;
  logic                 any_hit;
  logic                 sent_c;
  logic                 key_act;
  logic [7:0]           match_code, fill_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      out_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        in_q <= item_i;
      end
      if (cmd_i.execute) begin
        out_q <= out_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_q[i] <= 8'd0;
      end
      changed_q  <= 1'b0;
      protocol_q <= 8'd0;
      idle_q     <= 8'd0;
    end else if (cmd_i.execute) begin
      slot_q     <= slot_d;
      changed_q  <= changed_d;
      protocol_q <= protocol_d;
      idle_q     <= idle_d;
    end
  end

  // First slot that holds the code being searched for.
  always_comb begin
    logic seen;
    key_act    = (in_q.action == hidkbd_pkg::ActPress) ||
                 (in_q.action == hidkbd_pkg::ActRelease);
    match_code = (in_q.action == hidkbd_pkg::ActPress) ? 8'd0 : in_q.key_code;
    fill_code  = (in_q.action == hidkbd_pkg::ActPress) ? in_q.key_code : 8'd0;
    seen       = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit_first[i] = key_act && !seen && (slot_q[i] == match_code);
      seen         = seen || (slot_q[i] == match_code);
    end
    any_hit = |hit_first;
  end

  always_comb begin
    slot_d     = slot_q;
    changed_d  = changed_q;
    protocol_d = protocol_q;
    idle_d     = idle_q;
    sent_c     = 1'b0;
    out_d      = '0;

    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (hit_first[i]) begin
        slot_d[i] = fill_code;
      end
    end

    if (any_hit) begin
      // A change qualifies for sending when the link is active and the endpoint is free.
      sent_c    = in_q.link_active && !in_q.endpoint_busy;
      changed_d = !sent_c;
    end else if (in_q.action == hidkbd_pkg::ActReady) begin
      sent_c = in_q.link_active && !in_q.endpoint_busy &&
               ((idle_q != 8'd0) || changed_q);
      if (sent_c) begin
        changed_d = 1'b0;
      end
    end else if ((in_q.action == hidkbd_pkg::ActSetup) &&
                 ((in_q.request_type & hidkbd_pkg::TypeMask) == hidkbd_pkg::TypeClass)) begin
      unique case (in_q.request_code)
        hidkbd_pkg::RqGetReport: begin
          if (in_q.request_value[15:8] == hidkbd_pkg::ReportInput) begin
            out_d.handled    = 1'b1;
            out_d.reply_kind = hidkbd_pkg::KindReport;
          end
        end
        hidkbd_pkg::RqSetReport: begin
          out_d.handled = 1'b1;
        end
        hidkbd_pkg::RqGetProtocol: begin
          out_d.handled    = 1'b1;
          out_d.reply_kind = hidkbd_pkg::KindProtocol;
          out_d.reply_byte = protocol_q;
        end
        hidkbd_pkg::RqSetProtocol: begin
          out_d.handled = 1'b1;
          protocol_d    = in_q.request_value[7:0];
        end
        hidkbd_pkg::RqGetIdle: begin
          out_d.handled    = 1'b1;
          out_d.reply_kind = hidkbd_pkg::KindIdle;
          out_d.reply_byte = idle_q;
        end
        hidkbd_pkg::RqSetIdle: begin
          out_d.handled = 1'b1;
          idle_d        = in_q.request_value[15:8];
        end
        default: begin
        end
      endcase
    end

    out_d.send_report = sent_c;
    for (int i = 0; i < hidkbd_pkg::ShownSlots; i++) begin
      if (i < KEY_SLOTS) begin
        out_d.report_keys[8*i +: 8] = slot_d[i];
      end
    end
  end

  assign result_o = out_q;

  a_hit_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_first))
    else $error("more than one slot selected for update");

  a_send_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && sent_c) |=> !changed_q)
    else $error("changed flag survived a sent report");

  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> ($stable(protocol_q) && $stable(idle_q) && $stable(changed_q)))
    else $error("engine state moved without an execute command");

endmodule

// ----- hdl/hidkbd_ctrl.sv -----
// Controller of the HID keyboard report engine: capture/execute sequencing and output valid.
module hidkbd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hidkbd_pkg::cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_capture_then_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == StExec))
    else $error("captured item not followed by execute state");

  a_exec_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> out_free)
    else $error("result register overwritten before transfer");

  a_exec_gives_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_q)
    else $error("executed item produced no result");

endmodule
